// ===== rtl/mts_pkg.sv =====
`timescale 1ns / 1ps

package mts_pkg;

  localparam int DATA_WIDTH      = 32;
  localparam int FILL_WIDTH      = 8;
  localparam int STACK_DEPTH_DEF = 128;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                         mode;
    logic signed [DATA_WIDTH-1:0]  data_in;
  } req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]  popped_value;
    logic signed [DATA_WIDTH-1:0]  running_max;
    logic        [FILL_WIDTH-1:0]  fill_level;
    status_t                       status;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } mts_cmd_t;

endpackage

// ===== rtl/max_tracking_stack.sv =====
`timescale 1ns / 1ps

// LIFO stack of signed words that keeps, beside every entry, the maximum of
// all entries at or below it. Each request is a push or a pop and gives one
// response: popped value, running maximum, fill level and status (full push
// or empty pop changes nothing and reports an error). For each request the
// top entry is first read from the single stack memory into its read
// register, then compared, written back and loaded into the response register.
// No new request is taken while one is in progress: the next is taken in the
// cycle after a response is loaded, if that response drains then.

module max_tracking_stack
  import mts_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  mts_cmd_t cmd;

  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  mts_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

// ===== rtl/mts_ctrl.sv =====
`timescale 1ns / 1ps

module mts_ctrl
  import mts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output mts_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // a result slot is free by the execute cycle if it is empty or drains now
  assign req_stall   = !((state == S_IDLE) && (!rsp_valid || !rsp_stall));
  assign cmd.capture = req_valid && !req_stall;
  assign cmd.execute = (state == S_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cmd.execute) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/mts_datapath.sv =====
`timescale 1ns / 1ps

module mts_datapath
  import mts_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
  input  logic     clk,
  input  logic     rst,
  input  mts_cmd_t cmd,
  input  req_t     req,
  output rsp_t     rsp
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // each entry holds {value, max at or below}
  logic [2*DATA_WIDTH-1:0] mem [STACK_DEPTH];

  logic [CW-1:0]                 count;
  logic [CW-1:0]                 count_next;
  mode_t                         mode_q;
  logic signed [DATA_WIDTH-1:0]  data_q;
  logic [2*DATA_WIDTH-1:0]       rd_word;
  logic [CW-1:0]                 top_idx;
  logic signed [DATA_WIDTH-1:0]  rd_val;
  logic signed [DATA_WIDTH-1:0]  rd_max;
  logic signed [DATA_WIDTH-1:0]  push_max;
  logic                          is_full;
  logic                          is_empty;
  logic                          do_write;
  rsp_t                          rsp_next;

  assign top_idx  = count - CW'(1);
  assign rd_val   = rd_word[2*DATA_WIDTH-1:DATA_WIDTH];
  assign rd_max   = rd_word[DATA_WIDTH-1:0];
  assign is_full  = (count == CW'(STACK_DEPTH));
  assign is_empty = (count == '0);
  assign push_max = (!is_empty && (rd_max >= data_q)) ? rd_max : data_q;

  always_comb begin
    rsp_next   = '0;
    count_next = count;
    do_write   = 1'b0;
    if (mode_q == MODE_PUSH) begin
      if (is_full) begin
        rsp_next.status = STATUS_FULL;
      end else begin
        do_write             = 1'b1;
        count_next           = count + CW'(1);
        rsp_next.running_max = push_max;
        rsp_next.status      = STATUS_OK;
      end
    end else begin
      if (is_empty) begin
        rsp_next.status = STATUS_EMPTY;
      end else begin
        count_next            = top_idx;
        rsp_next.popped_value = rd_val;
        rsp_next.running_max  = rd_max;
        rsp_next.status       = STATUS_OK;
      end
    end
    rsp_next.fill_level = FILL_WIDTH'(count_next);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q  <= req.mode;
      data_q  <= req.data_in;
      rd_word <= mem[top_idx[AW-1:0]];
    end
    if (cmd.execute) begin
      rsp <= rsp_next;
      if (do_write) begin
        mem[count[AW-1:0]] <= {data_q, push_max};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.execute) begin
      count <= count_next;
    end
  end

endmodule

// ===== tb/max_tracking_stack_tb.sv =====
`timescale 1ns / 1ps

module max_tracking_stack_tb;
  import mts_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 1900;
  localparam int HOLD_START     = 1500;
  localparam int HOLD_CYCLES    = 400;
  localparam int QUIET_START    = 2500;
  localparam int QUIET_END      = 4000;
  localparam int DRAIN_CYCLES   = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  max_tracking_stack u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  req_t pending_ops[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  int   gen_depth = 0;
  int   gen_total = 0;

  // shadow copy of the stack contents
  logic signed [DATA_WIDTH-1:0] shadow_val [STACK_DEPTH_DEF];
  logic signed [DATA_WIDTH-1:0] shadow_max [STACK_DEPTH_DEF];
  int shadow_count = 0;

  function automatic rsp_t stack_apply(input req_t r);
    rsp_t e;
    logic signed [DATA_WIDTH-1:0] m;
    e = '0;
    e.status = STATUS_OK;
    if (r.mode == MODE_PUSH) begin
      if (shadow_count >= STACK_DEPTH_DEF) begin
        e.status = STATUS_FULL;
      end else begin
        m = r.data_in;
        if (shadow_count > 0 && shadow_max[shadow_count-1] >= r.data_in) begin
          m = shadow_max[shadow_count-1];
        end
        shadow_val[shadow_count] = r.data_in;
        shadow_max[shadow_count] = m;
        shadow_count = shadow_count + 1;
        e.running_max = m;
      end
    end else begin
      if (shadow_count == 0) begin
        e.status = STATUS_EMPTY;
      end else begin
        shadow_count = shadow_count - 1;
        e.popped_value = shadow_val[shadow_count];
        e.running_max  = shadow_max[shadow_count];
      end
    end
    e.fill_level = shadow_count[FILL_WIDTH-1:0];
    return e;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
      1: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
      2: return DATA_WIDTH'($signed($urandom_range(0, 8)) - 4);
      3: return {DATA_WIDTH{$urandom_range(0, 1) == 1}};
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(input mode_t md, input logic [DATA_WIDTH-1:0] d);
    req_t r;
    r.mode    = md;
    r.data_in = d;
    pending_ops.push_back(r);
    gen_total = gen_total + 1;
    if (md == MODE_PUSH && gen_depth < STACK_DEPTH_DEF) gen_depth = gen_depth + 1;
    if (md == MODE_POP && gen_depth > 0) gen_depth = gen_depth - 1;
  endtask

  task automatic report(input string field, input longint exp_v, input longint act_v);
    errors = errors + 1;
    $display("%0t mismatch %s: expected %0d actual %0d", $time, field, exp_v, act_v);
  endtask

  // transfer bookkeeping, prediction and checking
  logic req_sent = 1'b0;
  int   idle_cycles = 0;

  always @(posedge clk) begin
    req_t r;
    rsp_t e;
    req_sent <= req_valid && !req_stall;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        r = req;
        expected_rsps.push_back(stack_apply(r));
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          errors = errors + 1;
          $display("%0t unexpected response: expected none actual %h", $time, rsp);
        end else begin
          e = expected_rsps.pop_front();
          if (rsp.popped_value !== e.popped_value)
            report("popped_value", e.popped_value, rsp.popped_value);
          if (rsp.running_max !== e.running_max)
            report("running_max", e.running_max, rsp.running_max);
          if (rsp.fill_level !== e.fill_level)
            report("fill_level", e.fill_level, rsp.fill_level);
          if (rsp.status !== e.status)
            report("status", e.status, rsp.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // request driver
  int tx_cycles = 0;

  always @(negedge clk) begin
    tx_cycles <= tx_cycles + 1;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_sent) begin
      req_valid <= 1'b1;
    end else if (pending_ops.size() != 0 &&
                 ((tx_cycles >= QUIET_START && tx_cycles < QUIET_END) ||
                  $urandom_range(0, 99) >= 8)) begin
      req_valid <= 1'b1;
      req <= pending_ops.pop_front();
    end else begin
      req_valid <= 1'b0;
    end
  end

  // response side: random stalls, one long hold-off, one quiet stretch
  int rx_cycles = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    rx_cycles <= rx_cycles + 1;
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (rx_cycles == HOLD_START) begin
      rsp_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (rx_cycles >= QUIET_START && rx_cycles < QUIET_END) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < 8);
    end
  end

  initial begin
    int n;
    // pops on empty, extremes, ties on the maximum, ignored data on pop
    add_op(MODE_POP, '1);
    add_op(MODE_POP, '0);
    add_op(MODE_PUSH, {1'b1, {(DATA_WIDTH-1){1'b0}}});
    add_op(MODE_PUSH, {1'b1, {(DATA_WIDTH-1){1'b0}}});
    add_op(MODE_PUSH, '1);
    add_op(MODE_PUSH, {1'b0, {(DATA_WIDTH-1){1'b1}}});
    add_op(MODE_PUSH, '0);
    add_op(MODE_PUSH, -2);
    add_op(MODE_PUSH, {1'b0, {(DATA_WIDTH-1){1'b1}}});
    for (int i = 0; i < 7; i++) add_op(MODE_POP, (i % 2 == 0) ? '1 : '0);
    add_op(MODE_POP, 32'h5a5a_a5a5);
    add_op(MODE_PUSH, 5);
    add_op(MODE_PUSH, 0);
    add_op(MODE_PUSH, -5);
    add_op(MODE_POP, '1);
    add_op(MODE_POP, '1);
    add_op(MODE_POP, '1);
    add_op(MODE_POP, '0);

    while (gen_total < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          n = STACK_DEPTH_DEF - gen_depth + $urandom_range(1, 3);
          for (int i = 0; i < n; i++) add_op(MODE_PUSH, rand_word());
        end
        2, 3: begin
          n = gen_depth + $urandom_range(1, 2);
          for (int i = 0; i < n; i++) add_op(MODE_POP, $urandom);
        end
        default: begin
          n = $urandom_range(10, 40);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 55) add_op(MODE_PUSH, rand_word());
            else add_op(MODE_POP, $urandom);
          end
        end
      endcase
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mts_pkg.sv
rtl/mts_ctrl.sv
rtl/mts_datapath.sv
rtl/max_tracking_stack.sv
tb/max_tracking_stack_tb.sv
